[hdl/fct_pkg.sv]
// Shared types, codes and helpers of the fault code table.
package fct_pkg;

   localparam logic [2:0] CMD_SET_STATUS = 3'd0;
   localparam logic [2:0] CMD_GET_RECORD = 3'd1;
   localparam logic [2:0] CMD_CLEAR_ALL  = 3'd2;
   localparam logic [2:0] CMD_AGING_TICK = 3'd3;
   localparam logic [2:0] CMD_BROADCAST  = 3'd4;

   localparam logic [1:0] KIND_ACK   = 2'd0;
   localparam logic [1:0] KIND_REPLY = 2'd1;
   localparam logic [1:0] KIND_HDR   = 2'd2;
   localparam logic [1:0] KIND_ENTRY = 2'd3;

   localparam logic [1:0] CSR_AUTO_CLEAR = 2'd0;
   localparam logic [1:0] CSR_AGING_LIM  = 2'd1;
   localparam logic [1:0] CSR_FAILED     = 2'd2;
   localparam logic [1:0] CSR_NOT_DONE   = 2'd3;

   localparam logic [15:0] AGING_LIM_RST = 16'd40;
   localparam logic [7:0]  FAILED_RST    = 8'h01;
   localparam logic [7:0]  NOT_DONE_RST  = 8'h40;
   localparam logic [7:0]  COUNT_MAX     = 8'hFF;
   localparam logic [15:0] AGING_MAX     = 16'hFFFF;
   localparam logic [3:0]  SPN_HI_MASK   = 4'hF;

   typedef struct packed {
      logic [18:0] spn;
      logic [4:0]  fmi;
      logic [7:0]  status;
      logic [7:0]  count;
   } record_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_SCAN, ST_UPDATE, ST_SET_RSP, ST_GET_RSP,
      ST_FULL_RSP, ST_AGE_CHK, ST_COMPACT, ST_BCAST, ST_ACK
   } state_type;

   typedef enum logic [2:0] {
      RS_ACK, RS_FULL, RS_SET, RS_GET, RS_STAGED
   } rsp_sel_type;

   typedef struct packed {
      logic        load;
      logic        clear_tab;
      logic        age_inc;
      logic        append;
      logic        update;
      logic        idx_inc;
      logic        keep;
      logic        commit;
      logic        stage_hdr;
      logic        stage_entry;
      logic        clr_pend;
      logic        push;
      rsp_sel_type rsp_sel;
      logic        last;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       scan_end;
      logic       hit;
      logic       full;
      logic       failed;
      logic       not_done;
      logic       age_fire;
      logic       pending;
      logic       out_free;
   } dp_stat_type;

   // byte0 spn[7:0], byte1 spn[15:8], byte2 spn[18:16] | fmi[3:0]<<4, byte3 count
   function automatic logic [31:0] pack_word(input record_type r);
      logic [3:0] hi;
      hi = {1'b0, r.spn[18:16]} & SPN_HI_MASK;
      return {r.count, r.fmi[3:0], hi, r.spn[15:0]};
   endfunction

endpackage

[hdl/fct_ctrl.sv]
// Command sequencer of the fault code table.
module fct_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  fct_pkg::dp_stat_type stat,
   output fct_pkg::dp_cmd_type  cmd
);
   import fct_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.rsp_sel = RS_ACK;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (stat.cmd)
               CMD_SET_STATUS, CMD_GET_RECORD: state_in = ST_SCAN;
               CMD_CLEAR_ALL: begin
                  cmd.clear_tab = 1'b1;
                  state_in = ST_ACK;
               end
               CMD_AGING_TICK: begin
                  cmd.age_inc = 1'b1;
                  state_in = ST_AGE_CHK;
               end
               CMD_BROADCAST: begin
                  if (stat.pending) begin
                     cmd.stage_hdr = 1'b1;
                     state_in = ST_BCAST;
                  end else begin
                     state_in = ST_ACK;
                  end
               end
               default: state_in = ST_ACK;
            endcase
         end
         ST_SCAN: begin
            if (stat.cmd == CMD_GET_RECORD) begin
               if (stat.scan_end || stat.hit) state_in = ST_GET_RSP;
               else cmd.idx_inc = 1'b1;
            end else if (stat.scan_end) begin
               if (stat.full) begin
                  state_in = ST_FULL_RSP;
               end else begin
                  cmd.append = 1'b1;
                  state_in = ST_UPDATE;
               end
            end else if (stat.hit) begin
               state_in = ST_UPDATE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in = ST_SET_RSP;
         end
         ST_SET_RSP, ST_GET_RSP, ST_FULL_RSP, ST_ACK: begin
            case (state_ff)
               ST_SET_RSP:  cmd.rsp_sel = RS_SET;
               ST_GET_RSP:  cmd.rsp_sel = RS_GET;
               ST_FULL_RSP: cmd.rsp_sel = RS_FULL;
               default:     cmd.rsp_sel = RS_ACK;
            endcase
            cmd.last = 1'b1;
            if (stat.out_free) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_AGE_CHK: begin
            state_in = stat.age_fire ? ST_COMPACT : ST_ACK;
         end
         ST_COMPACT: begin
            if (stat.scan_end) begin
               cmd.commit = 1'b1;
               state_in = ST_ACK;
            end else begin
               cmd.keep    = !stat.not_done;
               cmd.idx_inc = 1'b1;
            end
         end
         ST_BCAST: begin
            cmd.rsp_sel = RS_STAGED;
            if (stat.scan_end) begin
               cmd.last = 1'b1;
               if (stat.out_free) begin
                  cmd.push     = 1'b1;
                  cmd.clr_pend = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (stat.failed) begin
               if (stat.out_free) begin
                  cmd.push        = 1'b1;
                  cmd.stage_entry = 1'b1;
                  cmd.idx_inc     = 1'b1;
               end
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[hdl/fct_datapath.sv]
// Record table, counters, config registers and result register.
module fct_datapath #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [2:0]           req_cmd,
   input  logic [31:0]          req_data,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_wdata,
   input  fct_pkg::dp_cmd_type  cmd,
   output fct_pkg::dp_stat_type stat,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output logic [55:0]          rsp_tdata,
   output logic [1:0]           rsp_tuser,
   output logic                 rsp_tlast
);
   import fct_pkg::*;

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   record_type  tab_ff [MAX_ENTRIES];
   logic [2:0]  cmd_ff;
   logic [18:0] spn_ff;
   logic [4:0]  fmi_ff;
   logic [7:0]  ns_ff;
   logic [CNT_W-1:0] idx_ff, wr_ff, used_ff;
   logic [15:0] aging_ff;
   logic        chg_ff;
   logic        auto_clear_ff;
   logic [15:0] aging_lim_ff;
   logic [7:0]  failed_ff, not_done_ff;
   logic [1:0]  stg_kind_ff;
   logic [31:0] stg_word_ff;
   logic        rsp_valid_ff, rsp_ok_ff, rsp_last_ff;
   logic [1:0]  rsp_kind_ff;
   logic [7:0]  rsp_status_ff, rsp_occ_ff;
   logic [4:0]  rsp_count_ff;
   logic [31:0] rsp_word_ff;

   record_type entry, upd;
   logic       found;
   logic       rsp_ok_in;
   logic [1:0] rsp_kind_in;
   logic [7:0] rsp_status_in, rsp_occ_in;
   logic [31:0] rsp_word_in;

   assign entry = tab_ff[idx_ff[IDX_W-1:0]];
   assign found = (idx_ff != used_ff);

   always_comb begin
      upd = entry;
      if (entry.status != ns_ff) begin
         upd.status = ns_ff;
         if (((ns_ff & failed_ff) != '0) && (entry.count != COUNT_MAX)) begin
            upd.count = entry.count + 8'd1;
         end
      end
   end

   always_comb begin
      stat.cmd      = cmd_ff;
      stat.scan_end = (idx_ff == used_ff);
      stat.hit      = (entry.spn == spn_ff) && (entry.fmi == fmi_ff);
      stat.full     = (used_ff == CNT_W'(MAX_ENTRIES));
      stat.failed   = (entry.status & failed_ff) != '0;
      stat.not_done = (entry.status & not_done_ff) != '0;
      stat.age_fire = auto_clear_ff && (aging_ff >= aging_lim_ff);
      stat.pending  = chg_ff;
      stat.out_free = !rsp_valid_ff || rsp_tready;
   end

   // table write port: append, in-place update, or compaction move
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         tab_ff[used_ff[IDX_W-1:0]] <= '{spn: spn_ff, fmi: fmi_ff, status: 8'd0,
                                         count: 8'd1};
      end else if (cmd.update) begin
         tab_ff[idx_ff[IDX_W-1:0]] <= upd;
      end else if (cmd.keep) begin
         tab_ff[wr_ff[IDX_W-1:0]] <= entry;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_cmd;
         spn_ff <= req_data[18:0];
         fmi_ff <= req_data[23:19];
         ns_ff  <= req_data[31:24];
      end
      if (cmd.stage_hdr) begin
         stg_kind_ff <= KIND_HDR;
         stg_word_ff <= '0;
      end else if (cmd.stage_entry) begin
         stg_kind_ff <= KIND_ENTRY;
         stg_word_ff <= pack_word(entry);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         wr_ff    <= '0;
         used_ff  <= '0;
         aging_ff <= '0;
         chg_ff   <= 1'b0;
      end else begin
         if (cmd.load) begin
            idx_ff <= '0;
            wr_ff  <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
         if (cmd.keep) wr_ff <= wr_ff + CNT_W'(1);
         if (cmd.append) used_ff <= used_ff + CNT_W'(1);
         else if (cmd.clear_tab) used_ff <= '0;
         else if (cmd.commit) used_ff <= wr_ff;
         if (cmd.age_inc && (aging_ff != AGING_MAX)) aging_ff <= aging_ff + 16'd1;
         if (cmd.clear_tab || (cmd.update && (entry.status != ns_ff)) ||
             (cmd.commit && (wr_ff != used_ff))) begin
            chg_ff <= 1'b1;
         end else if (cmd.clr_pend) begin
            chg_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_clear_ff <= 1'b0;
         aging_lim_ff  <= AGING_LIM_RST;
         failed_ff     <= FAILED_RST;
         not_done_ff   <= NOT_DONE_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_AUTO_CLEAR: auto_clear_ff <= csr_wdata[0];
            CSR_AGING_LIM:  aging_lim_ff  <= csr_wdata;
            CSR_FAILED:     failed_ff     <= csr_wdata[7:0];
            CSR_NOT_DONE:   not_done_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_kind_in   = KIND_ACK;
      rsp_ok_in     = 1'b1;
      rsp_status_in = '0;
      rsp_occ_in    = '0;
      rsp_word_in   = '0;
      case (cmd.rsp_sel)
         RS_ACK: ;
         RS_FULL: rsp_ok_in = 1'b0;
         RS_SET: begin
            rsp_status_in = entry.status;
            rsp_occ_in    = entry.count;
         end
         RS_GET: begin
            rsp_kind_in = KIND_REPLY;
            rsp_ok_in   = found;
            if (found) begin
               rsp_status_in = entry.status;
               rsp_occ_in    = entry.count;
            end
         end
         RS_STAGED: begin
            rsp_kind_in = stg_kind_ff;
            rsp_word_in = stg_word_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.push) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_ok_ff     <= rsp_ok_in;
         rsp_status_ff <= rsp_status_in;
         rsp_occ_ff    <= rsp_occ_in;
         rsp_count_ff  <= 5'(used_ff);
         rsp_word_ff   <= rsp_word_in;
         rsp_last_ff   <= cmd.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_word_ff, rsp_count_ff, rsp_occ_ff, rsp_status_ff,
                        rsp_ok_ff};

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(MAX_ENTRIES))
      else $error("record count above table depth");
   a_wr_behind: assert property (@(posedge clock) disable iff (reset)
      wr_ff <= idx_ff)
      else $error("compaction write index ahead of read index");
   a_pend_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_pend |=> !chg_ff)
      else $error("pending flag survived broadcast");
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before transfer");

endmodule

[hdl/fault_code_table_top.sv]
// Top level of the fault code table: sequencer plus datapath.
//
//  channel   dir  signals                          notes
//  req       in   tvalid/tready/tdata[31:0]/tuser   one command per transfer
//  rsp       out  tvalid/tready/tdata[55:0]/tuser   1 to MAX_ENTRIES+1 transfers, tlast ends
//  csr       in   we/index[1:0]/wdata[15:0]         write only, idle time only
//
// Set_status compares one record per cycle over a table of N records, then
// appends or updates and responds; get_record searches the same way. Aging with
// auto clear moves one record per cycle over the single table write port.
// Any step that emits waits while the result register still holds an untaken result.
// Reset is synchronous and clears control state; record contents are not cleared.
// Commands are taken one at a time; rsp back-pressure stalls the sequencer.
module fault_code_table_top #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // param_number[18:0], failure_mode[23:19], new_status[31:24]
   input  logic [2:0]  req_tuser,   // cmd[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // ok[0], status_out[8:1], occurrences[16:9],
                                    // entry_count[21:17], packed_word[53:22], zero[55:54]
   output logic [1:0]  rsp_tuser,   // kind[1:0]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import fct_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // sequencer: one state per search, compaction or emit step
   fct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (dp_stat),
      .cmd        (dp_cmd)
   );

   // table, counters and the result register that decouples rsp stalls
   fct_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_cmd    (req_tuser),
      .req_data   (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (dp_cmd),
      .stat       (dp_stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
